### rtl/adts_frame_extractor_assert.svh
// ----------------------------------------------------------------------------
// adts_frame_extractor_assert.svh
// Assertion macros shared by the ADTS frame extractor RTL.
// ----------------------------------------------------------------------------
`ifndef ADTS_FRAME_EXTRACTOR_ASSERT_SVH
`define ADTS_FRAME_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define AFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define AFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/afe_pkg.sv
// ----------------------------------------------------------------------------
// afe_pkg
// Types, constants and header decode for the ADTS frame extractor.
// ----------------------------------------------------------------------------
package afe_pkg;

  localparam int HEADER_BYTES = 7;
  localparam int LEN_W        = 13;

  localparam logic [2:0]       HDR_LAST_IDX   = 3'(HEADER_BYTES - 1);
  localparam logic [LEN_W-1:0] HDR_LEN        = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 13'd8191;
  localparam logic [7:0]       SYNC_BYTE      = 8'hFF;
  localparam logic [3:0]       SYNC_NIBBLE    = 4'hF;

  typedef enum logic [1:0] {
    STATUS_FRAME    = 2'd0,
    STATUS_BAD_SYNC = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_t;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic             mpeg_id;
    logic             protection_absent;
    logic [1:0]       profile;
    logic [3:0]       sampling_index;
    logic [2:0]       channel_config;
    logic [LEN_W-1:0] frame_length;
    logic [10:0]      buffer_fullness;
    logic [1:0]       raw_blocks;
  } hdr_fields_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    status_t     status;
    hdr_fields_t fields;
  } out_res_t;

  // Pull the fixed header fields out of the seven header bytes
  function automatic hdr_fields_t afe_decode(input hdr_bytes_t h);
    hdr_fields_t f;
    f.mpeg_id           = h[1][3];
    f.protection_absent = h[1][0];
    f.profile           = h[2][7:6];
    f.sampling_index    = h[2][5:2];
    f.channel_config    = {h[2][0], h[3][7:6]};
    f.frame_length      = {h[3][1:0], h[4], h[5][7:5]};
    f.buffer_fullness   = {h[5][4:0], h[6][7:2]};
    f.raw_blocks        = h[6][1:0];
    return f;
  endfunction

endpackage

### rtl/adts_frame_extractor.sv
// ----------------------------------------------------------------------------
// adts_frame_extractor
// ADTS header parser and frame byte extractor for an AAC byte stream.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while in_ready is high. Header bytes are gathered
// without output; on the seventh byte the sync word and frame length are
// checked in the same cycle. A bad header yields one error transaction and the
// next seven bytes are read as a new header. A good header is replayed from the
// header registers through the single output register, one byte per cycle
// unless the output stalls, and input is held off during that replay; payload
// bytes then pass straight through at one per cycle unless the output stalls.
// Every result is registered in the output register. max_frame_length may be
// rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module adts_frame_extractor
  import afe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              first_byte,
  output logic              last_byte,
  output logic [1:0]        status,
  output logic              mpeg_id,
  output logic              protection_absent,
  output logic [1:0]        profile,
  output logic [3:0]        sampling_index,
  output logic [2:0]        channel_config,
  output logic [LEN_W-1:0]  frame_length,
  output logic [10:0]       buffer_fullness,
  output logic [1:0]        raw_blocks
);

  `include "adts_frame_extractor_assert.svh"

  logic [LEN_W-1:0] max_frame_length;
  hdr_bytes_t       header_store;
  logic [2:0]       header_count;
  logic             in_payload;
  logic [LEN_W-1:0] bytes_remaining;
  hdr_fields_t      frame_fields;
  logic             replay_active;
  logic [2:0]       replay_idx;
  out_res_t         out_res;

  logic        load_ok;
  logic        in_fire;
  logic        hdr_done;
  logic        replay_step;
  logic        sync_ok;
  logic        len_ok;
  logic        pay_last;
  logic        out_load;
  hdr_bytes_t  hdr_now;
  hdr_fields_t fld_now;
  out_res_t    out_res_next;

  // Handshake
  assign load_ok     = !out_valid || out_ready;
  assign in_ready    = !replay_active &&
                       (load_ok || (!in_payload && header_count != HDR_LAST_IDX));
  assign in_fire     = in_valid && in_ready;
  assign hdr_done    = in_fire && !in_payload && header_count == HDR_LAST_IDX;
  assign replay_step = replay_active && load_ok;
  assign pay_last    = bytes_remaining <= LEN_W'(1);

  // Assemble the header as it stands with the incoming byte in the last slot
  always_comb begin
    hdr_now                 = header_store;
    hdr_now[HDR_LAST_IDX]   = data_byte;
  end

  assign fld_now = afe_decode(hdr_now);
  assign sync_ok = hdr_now[0] == SYNC_BYTE && hdr_now[1][7:4] == SYNC_NIBBLE;
  assign len_ok  = !(fld_now.frame_length > max_frame_length ||
                     fld_now.frame_length < HDR_LEN);

  // Select the next result: header replay, payload pass-through, header verdict
  always_comb begin
    out_res_next        = out_res;
    out_load            = 1'b0;
    if (replay_step) begin
      out_load            = 1'b1;
      out_res_next.data   = header_store[replay_idx];
      out_res_next.first  = 1'b0;
      out_res_next.last   = replay_idx == HDR_LAST_IDX &&
                            frame_fields.frame_length == HDR_LEN;
      out_res_next.status = STATUS_FRAME;
      out_res_next.fields = frame_fields;
    end else if (in_fire && in_payload) begin
      out_load            = 1'b1;
      out_res_next.data   = data_byte;
      out_res_next.first  = 1'b0;
      out_res_next.last   = pay_last;
      out_res_next.status = STATUS_FRAME;
      out_res_next.fields = frame_fields;
    end else if (hdr_done) begin
      out_load            = 1'b1;
      out_res_next.first  = 1'b0;
      out_res_next.last   = 1'b0;
      out_res_next.data   = 8'd0;
      if (!sync_ok) begin
        out_res_next.status = STATUS_BAD_SYNC;
        out_res_next.fields = '0;
      end else if (!len_ok) begin
        out_res_next.status = STATUS_BAD_LEN;
        out_res_next.fields = fld_now;
      end else begin
        out_res_next.data   = hdr_now[0];
        out_res_next.first  = 1'b1;
        out_res_next.status = STATUS_FRAME;
        out_res_next.fields = fld_now;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_frame_length <= cfg_wr_data;
    end
  end

  // Gather header bytes
  always_ff @(posedge clk) begin
    if (in_fire && !in_payload) begin
      header_store[header_count] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
    end else if (in_fire && !in_payload) begin
      header_count <= (header_count == HDR_LAST_IDX) ? 3'd0 : header_count + 3'd1;
    end
  end

  // Latch decoded fields of an accepted frame
  always_ff @(posedge clk) begin
    if (hdr_done && sync_ok && len_ok) begin
      frame_fields <= fld_now;
    end
  end

  // Replay header bytes after the first one
  always_ff @(posedge clk) begin
    if (rst) begin
      replay_active <= 1'b0;
      replay_idx    <= '0;
    end else if (hdr_done && sync_ok && len_ok) begin
      replay_active <= 1'b1;
      replay_idx    <= 3'd1;
    end else if (replay_step) begin
      if (replay_idx == HDR_LAST_IDX) begin
        replay_active <= 1'b0;
      end
      replay_idx <= (replay_idx == HDR_LAST_IDX) ? 3'd0 : replay_idx + 3'd1;
    end
  end

  // Count payload bytes down to the end of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
    end else if (hdr_done && sync_ok && len_ok) begin
      in_payload      <= fld_now.frame_length > HDR_LEN;
      bytes_remaining <= (fld_now.frame_length > HDR_LEN) ?
                         fld_now.frame_length - HDR_LEN : '0;
    end else if (in_fire && in_payload) begin
      if (pay_last) begin
        in_payload      <= 1'b0;
        bytes_remaining <= '0;
      end else begin
        bytes_remaining <= bytes_remaining - LEN_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= out_res_next;
    end
  end

  assign out_byte          = out_res.data;
  assign first_byte        = out_res.first;
  assign last_byte         = out_res.last;
  assign status            = out_res.status;
  assign mpeg_id           = out_res.fields.mpeg_id;
  assign protection_absent = out_res.fields.protection_absent;
  assign profile           = out_res.fields.profile;
  assign sampling_index    = out_res.fields.sampling_index;
  assign channel_config    = out_res.fields.channel_config;
  assign frame_length      = out_res.fields.frame_length;
  assign buffer_fullness   = out_res.fields.buffer_fullness;
  assign raw_blocks        = out_res.fields.raw_blocks;

  // Checks
  `AFE_ASSERT_NOW(a_replay_blocks_input, replay_active, !in_ready,
    "input accepted during header replay")
  `AFE_ASSERT_NOW(a_payload_count_clear, in_payload || replay_active,
    header_count == 3'd0, "header count not clear while a frame is open")
  `AFE_ASSERT_NOW(a_replay_idx_range, replay_active,
    replay_idx != 3'd0, "replay index out of range")
  `AFE_ASSERT_NOW(a_first_is_frame, out_valid && first_byte,
    out_res.status == STATUS_FRAME, "first mark on an error result")
  `AFE_ASSERT_NEXT(a_good_header_first, hdr_done && sync_ok && len_ok,
    out_valid && first_byte && replay_active, "good header did not start a frame")

endmodule
